/* hdl/mbrr_pkg.sv */
// Shared types, constants and functions of the Modbus input register reader.
`default_nettype none
package mbrr_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgTimeoutMs = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxValue = 1'd1;
  localparam logic [15:0] TimeoutMsRst = 16'd1000;
  localparam logic [15:0] MaxValueRst = 16'd20000;

  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeByte = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;

  localparam logic KindReq = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam logic [2:0] StatOk = 3'd0;
  localparam logic [2:0] StatTimeout = 3'd1;
  localparam logic [2:0] StatBadHeader = 3'd2;
  localparam logic [2:0] StatBadCrc = 3'd3;
  localparam logic [2:0] StatRange = 3'd4;

  localparam logic [7:0] SlaveAddr = 8'hFE;
  localparam logic [7:0] FuncReadInput = 8'h04;
  localparam logic [7:0] ReplyCount = 8'h02;
  localparam logic [2:0] ReplyLastIdx = 3'd6;
  localparam logic [2:0] ReplyCrcEnd = 3'd5;
  localparam logic [2:0] ReqLastIdx = 3'd7;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef struct packed {
    logic        is_report;
    logic [2:0]  status;
    logic [15:0] reading;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [2:0]  status;
    logic [15:0] reading;
  } beat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] req_head(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'hFE;
      3'd1: r = 8'h04;
      3'd2: r = 8'h00;
      3'd3: r = 8'h03;
      3'd4: r = 8'h00;
      3'd5: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] req_crc();
    logic [15:0] c;
    c = CrcInit;
    for (int i = 0; i < 6; i++) begin
      c = crc_byte(c, req_head(3'(i)));
    end
    return c;
  endfunction

  localparam logic [15:0] ReqCrc = req_crc();

  function automatic logic [7:0] req_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd6: r = ReqCrc[7:0];
      3'd7: r = ReqCrc[15:8];
      default: r = req_head(idx);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/mbrr_front.sv */
// Front end: accepts items, tracks the reply and timeout, and queues result commands.
`default_nettype none
module mbrr_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire logic [1:0]             mode_i,
  input  wire logic [7:0]             rx_byte_i,
  input  wire logic [15:0]            timeout_ms_i,
  input  wire logic [15:0]            max_value_i,
  output logic                        push_o,
  output mbrr_pkg::cmd_t              cmd_o
);
  import mbrr_pkg::*;

  logic        waiting_q, waiting_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] crc_q, crc_d;
  logic        hdr_good_q, hdr_good_d;
  logic [7:0]  val_hi_q, val_hi_d;
  logic [7:0]  val_lo_q, val_lo_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] got_crc;
  logic [15:0] value;
  logic [15:0] elapsed_inc;

  assign got_crc = {rx_byte_i, crc_lo_q};
  assign value = {val_hi_q, val_lo_q};
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    waiting_d = waiting_q;
    cnt_d = cnt_q;
    elapsed_d = elapsed_q;
    crc_d = crc_q;
    hdr_good_d = hdr_good_q;
    val_hi_d = val_hi_q;
    val_lo_d = val_lo_q;
    crc_lo_d = crc_lo_q;
    push_o = 1'b0;
    cmd_o = '0;
    if (acc_i) begin
      case (mode_i)
        ModeStart: begin
          waiting_d = 1'b1;
          cnt_d = 3'd0;
          elapsed_d = 16'd0;
          crc_d = CrcInit;
          hdr_good_d = 1'b1;
          val_hi_d = 8'd0;
          val_lo_d = 8'd0;
          crc_lo_d = 8'd0;
          push_o = 1'b1;
          cmd_o.is_report = KindReq;
        end
        ModeByte: begin
          if (waiting_q && (cnt_q <= ReplyLastIdx)) begin
            unique case (cnt_q)
              3'd0: if (rx_byte_i != SlaveAddr) hdr_good_d = 1'b0;
              3'd1: if (rx_byte_i != FuncReadInput) hdr_good_d = 1'b0;
              3'd2: if (rx_byte_i != ReplyCount) hdr_good_d = 1'b0;
              3'd3: val_hi_d = rx_byte_i;
              3'd4: val_lo_d = rx_byte_i;
              3'd5: crc_lo_d = rx_byte_i;
              default: ;
            endcase
            if (cnt_q < ReplyCrcEnd) begin
              crc_d = crc_byte(crc_q, rx_byte_i);
            end
            cnt_d = cnt_q + 3'd1;
            if (cnt_q == ReplyLastIdx) begin
              waiting_d = 1'b0;
              push_o = 1'b1;
              cmd_o.is_report = KindReport;
              if (!hdr_good_q) begin
                cmd_o.status = StatBadHeader;
              end else if (got_crc != crc_q) begin
                cmd_o.status = StatBadCrc;
              end else begin
                cmd_o.reading = value;
                cmd_o.status = ((value == 16'd0) || (value > max_value_i)) ? StatRange : StatOk;
              end
            end
          end
        end
        ModeTick: begin
          if (waiting_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_ms_i) begin
              waiting_d = 1'b0;
              push_o = 1'b1;
              cmd_o.is_report = KindReport;
              cmd_o.status = StatTimeout;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      cnt_q <= 3'd0;
      elapsed_q <= 16'd0;
      crc_q <= CrcInit;
      hdr_good_q <= 1'b1;
      val_hi_q <= 8'd0;
      val_lo_q <= 8'd0;
      crc_lo_q <= 8'd0;
    end else begin
      waiting_q <= waiting_d;
      cnt_q <= cnt_d;
      elapsed_q <= elapsed_d;
      crc_q <= crc_d;
      hdr_good_q <= hdr_good_d;
      val_hi_q <= val_hi_d;
      val_lo_q <= val_lo_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/mbrr_queue.sv */
// Short command queue between the front end and the back end.
`default_nettype none
module mbrr_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire mbrr_pkg::cmd_t              cmd_i,
  input  wire logic                        pop_i,
  output mbrr_pkg::cmd_t                   head_o,
  output logic                             empty_o,
  output logic                             full_o,
  output logic [mbrr_pkg::QCntW-1:0]       count_o
);
  import mbrr_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == QCntW'(QDepth));
  assign count_o = cnt_q;
  assign head_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/mbrr_back.sv */
// Back end: expands queued commands into output beats through an output register.
`default_nettype none
module mbrr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mbrr_pkg::cmd_t    head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mbrr_pkg::beat_t        beat_o
);
  import mbrr_pkg::*;

  logic       valid_q;
  beat_t      beat_q, beat_d;
  logic [2:0] idx_q;
  logic       load;

  assign load = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && (head_i.is_report || (idx_q == ReqLastIdx));
  assign out_valid_o = valid_q;
  assign beat_o = beat_q;

  always_comb begin
    beat_d = '0;
    if (head_i.is_report) begin
      beat_d.kind = KindReport;
      beat_d.status = head_i.status;
      beat_d.reading = head_i.reading;
    end else begin
      beat_d.kind = KindReq;
      beat_d.tx_byte = req_byte(idx_q);
      beat_d.last_byte = (idx_q == ReqLastIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      if (load && !head_i.is_report) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/modbus_input_register_reader_core.sv */
// Top level of the Modbus RTU read-input-register master.
// The slave stream carries one item per beat: tuser holds the mode (start,
// received byte, millisecond tick) and tdata the received byte. The master
// stream carries result beats: tuser is the kind (request byte or report),
// tlast marks the eighth request byte, and tdata packs the request byte,
// status and reading. Registers timeout_ms and max_value are written through
// the plain write port; the user must write them only while the block is
// idle, which the block itself does not enforce. An item is taken every cycle
// while the four-entry command queue has room. A start item yields eight
// request beats, a completed reply or a timeout one report beat. With the
// queue empty and the output free, the command for an item is written into
// the queue when the item is accepted and is then loaded into the output
// register, where its first beat becomes valid. The output register then drains
// one beat per cycle while the receiver is ready. When the receiver stalls, the
// output register holds its beat, the queue fills, and tready falls once the
// queue is full. Reset clears the queue, the output valid flag and the reply
// state, and loads a timeout of 1000 ms and a value limit of 20000.
`default_nettype none
module modbus_input_register_reader_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // rx_byte
  input  wire logic [1:0]                    s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // tx_byte, status, reading, zero pad
  output logic                               m_axis_tlast,
  output logic [0:0]                         m_axis_tuser,  // kind
  input  wire logic                          cfg_we_i,
  input  wire logic [mbrr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mbrr_pkg::CfgW-1:0]     cfg_data_i
);
  import mbrr_pkg::*;

  logic [15:0]      timeout_ms_q;
  logic [15:0]      max_value_q;
  logic             in_acc;
  logic             push;
  cmd_t             cmd;
  cmd_t             head;
  logic             q_empty, q_full, pop;
  logic [QCntW-1:0] q_count;
  beat_t            beat;

  assign s_axis_tready = !q_full;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ms_q <= TimeoutMsRst;
      max_value_q <= MaxValueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTimeoutMs: timeout_ms_q <= cfg_data_i;
        CfgMaxValue: max_value_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mbrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .mode_i       (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata),
    .timeout_ms_i (timeout_ms_q),
    .max_value_i  (max_value_q),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  mbrr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  mbrr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .beat_o      (beat)
  );

  assign m_axis_tdata = {5'd0, beat.reading, beat.status, beat.tx_byte};
  assign m_axis_tlast = beat.last_byte;
  assign m_axis_tuser = beat.kind;

  a_last_only_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] == KindReq)
    else $error("tlast set on a report beat");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == KindReport) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("report beat carries a request byte");

  a_start_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == ModeStart) |=> (q_count != '0))
    else $error("start item did not reach the command queue");

  a_request_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == KindReq) |-> m_axis_tdata[26:8] == 19'd0)
    else $error("request beat carries status or reading");

endmodule
`default_nettype wire

/* tb/modbus_input_register_reader_core_tb.sv */
// Testbench for the Modbus read-input-register core: directed and random stream traffic checked against a model.
`timescale 1ns / 100ps
`default_nettype none
module modbus_input_register_reader_core_tb;
  import mbrr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 16;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [47:0] RequestHead = 48'hFE_04_00_03_00_01;
  localparam int unsigned ReplyLen = 7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx;
  } link_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  link_item_t pending_items[$];
  beat_t      expected_beats[$];
  int         queued_count;
  int         mismatches;
  int         cycle_cnt;
  bit         in_taken;
  bit         calm;
  bit         sender_hold;

  logic [15:0] timeout_limit;
  logic [15:0] max_limit;
  logic        awaiting_reply;
  logic [2:0]  rx_count;
  logic [15:0] ms_count;
  logic [15:0] rx_crc;
  logic        header_ok;
  logic [7:0]  value_hi;
  logic [7:0]  value_lo;
  logic [7:0]  crc_lo_rx;

  modbus_input_register_reader_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
    end
    return acc;
  endfunction

  task automatic clear_reception();
    awaiting_reply = 1'b0;
    rx_count = '0;
    ms_count = '0;
    rx_crc = 16'hFFFF;
    header_ok = 1'b1;
    value_hi = '0;
    value_lo = '0;
    crc_lo_rx = '0;
  endtask

  task automatic push_report(input logic [2:0] status, input logic [15:0] reading);
    beat_t bt;
    bt = '0;
    bt.kind = KindReport;
    bt.status = status;
    bt.reading = reading;
    expected_beats.push_back(bt);
  endtask

  task automatic modbus_master_step(input logic [1:0] mode, input logic [7:0] b);
    beat_t       bt;
    logic [15:0] crc;
    logic [15:0] got_crc;
    logic [15:0] value;
    case (mode)
      ModeStart: begin
        clear_reception();
        crc = 16'hFFFF;
        for (int k = 0; k < 8; k++) begin
          bt = '0;
          bt.kind = KindReq;
          if (k < 6) begin
            bt.tx_byte = RequestHead[47 - 8 * k -: 8];
            crc = crc16_step(crc, bt.tx_byte);
          end else begin
            bt.tx_byte = (k == 6) ? crc[7:0] : crc[15:8];
          end
          bt.last_byte = (k == 7);
          expected_beats.push_back(bt);
        end
        awaiting_reply = 1'b1;
      end
      ModeByte: begin
        if (awaiting_reply && rx_count < ReplyLen) begin
          case (rx_count)
            3'd0: if (b != SlaveAddr) header_ok = 1'b0;
            3'd1: if (b != FuncReadInput) header_ok = 1'b0;
            3'd2: if (b != ReplyCount) header_ok = 1'b0;
            3'd3: value_hi = b;
            3'd4: value_lo = b;
            3'd5: crc_lo_rx = b;
            default: ;
          endcase
          if (rx_count < 5) rx_crc = crc16_step(rx_crc, b);
          rx_count = rx_count + 3'd1;
          if (rx_count == ReplyLen) begin
            got_crc = {b, crc_lo_rx};
            value = {value_hi, value_lo};
            if (!header_ok) begin
              push_report(StatBadHeader, 16'h0000);
            end else if (got_crc != rx_crc) begin
              push_report(StatBadCrc, 16'h0000);
            end else if (value == 16'h0000 || value > max_limit) begin
              push_report(StatRange, value);
            end else begin
              push_report(StatOk, value);
            end
            awaiting_reply = 1'b0;
          end
        end
      end
      ModeTick: begin
        if (awaiting_reply) begin
          if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
          if (ms_count >= timeout_limit) begin
            push_report(StatTimeout, 16'h0000);
            awaiting_reply = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_beat(input string what, input beat_t want, input beat_t got,
                             input logic [4:0] pad);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want kind=%0d tx=%02h last=%0d status=%0d reading=%04h", what,
               want.kind, want.tx_byte, want.last_byte, want.status, want.reading);
      $display("  got kind=%0d tx=%02h last=%0d status=%0d reading=%04h pad=%02h",
               got.kind, got.tx_byte, got.last_byte, got.status, got.reading, pad);
    end
  endtask

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        modbus_master_step(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser[0];
        got.tx_byte = m_axis_tdata[7:0];
        got.last_byte = m_axis_tlast;
        got.status = m_axis_tdata[10:8];
        got.reading = m_axis_tdata[26:11];
        if (expected_beats.size() == 0) begin
          report_beat("unexpected beat", '0, got, m_axis_tdata[31:27]);
        end else begin
          want = expected_beats.pop_front();
          if (got.kind != want.kind || got.tx_byte != want.tx_byte ||
              got.last_byte != want.last_byte || got.status != want.status ||
              got.reading != want.reading || m_axis_tdata[31:27] != 5'd0) begin
            report_beat("beat mismatch", want, got, m_axis_tdata[31:27]);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    link_item_t nxt;
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(99) >= 7);
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pending_items.size() != 0 && !sender_hold && (calm || $urandom_range(99) >= 7)) begin
          nxt = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.mode;
          s_axis_tdata <= nxt.rx;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] mode, input logic [7:0] b);
    link_item_t it;
    it.mode = mode;
    it.rx = b;
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic add_reply(input logic [15:0] value, input int bad_pos, input int tick_pct,
                           input int keep);
    logic [7:0]  r [0:6];
    logic [15:0] crc;
    r[0] = SlaveAddr;
    r[1] = FuncReadInput;
    r[2] = ReplyCount;
    r[3] = value[15:8];
    r[4] = value[7:0];
    crc = 16'hFFFF;
    for (int k = 0; k < 5; k++) crc = crc16_step(crc, r[k]);
    r[5] = crc[7:0];
    r[6] = crc[15:8];
    if (bad_pos >= 0 && bad_pos < ReplyLen) r[bad_pos] = r[bad_pos] ^ 8'($urandom_range(255, 1));
    for (int k = 0; k < keep; k++) begin
      if ($urandom_range(99) < tick_pct) add_item(ModeTick, 8'($urandom));
      add_item(ModeByte, r[k]);
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return max_limit;
      2: return max_limit + 16'd1;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_exchange();
    int r;
    add_item(ModeStart, 8'($urandom));
    r = $urandom_range(99);
    if (r < 60) begin
      add_reply(pick_value(), ($urandom_range(99) < 25) ? int'($urandom_range(6)) : -1, 8, 7);
    end else if (r < 78) begin
      add_reply(pick_value(), -1, 10, $urandom_range(6));
      repeat ($urandom_range(1, 6)) add_item(ModeTick, 8'($urandom));
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) add_item(2'($urandom_range(3)), 8'($urandom));
    end else begin
      add_reply(pick_value(), -1, 0, 7);
      repeat ($urandom_range(1, 3)) add_item(ModeByte, 8'($urandom));
    end
  endtask

  task automatic add_random(input int n_items);
    int first;
    first = queued_count;
    while (queued_count - first < n_items) add_exchange();
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == CfgTimeoutMs) timeout_limit = value;
    else max_limit = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    cycle_cnt = 0;
    mismatches = 0;
    queued_count = 0;
    in_taken = 1'b0;
    calm = 1'b0;
    sender_hold = 1'b0;
    timeout_limit = TimeoutMsRst;
    max_limit = MaxValueRst;
    clear_reception();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_item(ModeByte, 8'hFF);
    add_item(ModeTick, 8'h00);
    add_item(ModeUnused, 8'hA5);
    add_item(ModeStart, 8'h00);
    add_reply(MaxValueRst, -1, 0, 7);
    add_item(ModeStart, 8'hFF);
    add_reply(16'h1234, -1, 0, 2);
    add_item(ModeStart, 8'h5A);
    add_reply(16'hFFFF, -1, 0, 7);
    add_item(ModeByte, 8'h00);
    wait_idle();

    write_reg(CfgTimeoutMs, 16'd1);
    write_reg(CfgMaxValue, 16'd0);
    add_item(ModeStart, 8'h00);
    add_item(ModeTick, 8'hFF);
    add_item(ModeStart, 8'h00);
    add_reply(16'h0001, 1, 0, 7);
    add_item(ModeStart, 8'h00);
    add_reply(16'h0001, 6, 0, 7);
    add_item(ModeStart, 8'h00);
    add_reply(16'h0001, -1, 0, 7);
    add_random(25);
    wait_idle();

    write_reg(CfgTimeoutMs, 16'hFFFF);
    write_reg(CfgMaxValue, 16'hFFFF);
    calm = 1'b1;
    add_item(ModeStart, 8'h00);
    add_reply(16'hFFFF, -1, 0, 7);
    add_random(25);
    while (pending_items.size() > 20) @(posedge clk_i);
    sender_hold = 1'b1;
    while (expected_beats.size() != 0) @(posedge clk_i);
    sender_hold = 1'b0;
    wait_idle();
    calm = 1'b0;

    write_reg(CfgTimeoutMs, 16'($urandom_range(8, 2)));
    write_reg(CfgMaxValue, 16'($urandom));
    add_random(20);
    wait_idle();

    write_reg(CfgTimeoutMs, 16'd0);
    write_reg(CfgMaxValue, 16'd1);
    add_random(20);
    wait_idle();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
